@@ rtl/hsi_pkg.sv @@
// Package: payload types, constants and the per-stage datapath of the RGB to HSI pipeline.
`default_nettype none
package hsi_pkg;

    localparam int NUM_STAGES = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int DIV_BITS = 10;

    localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
    localparam logic [19:0] INT_RECIP = 20'd877240;     // floor(2^28 / 306)
    localparam logic [8:0] INT_DIV = 9'd306;
    localparam logic [10:0] MILLI_MAX = 11'd1000;
    localparam logic [32:0] QUARTER_TURN = 33'h0_4000_0000;
    localparam logic [32:0] HALF_TURN = 33'h0_8000_0000;
    localparam logic [32:0] FULL_TURN = 33'h1_0000_0000;
    localparam logic [15:0] HUE_SCALE = 16'd36000;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } hsi_in_t;

    typedef struct packed {
        logic [15:0] hue_centideg;
        logic [9:0]  saturation_milli;
        logic [9:0]  intensity_milli;
    } hsi_out_t;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [9:0]         sum;
        logic               x_neg;
        logic               y_neg;
        logic [20:0]        sat_rem;
        logic [10:0]        sat_den;
        logic [9:0]         sat_q;
        logic [18:0]        int_n;
        logic [10:0]        int_q;
        logic signed [43:0] cx;
        logic signed [43:0] cy;
        logic signed [33:0] cz;
        logic [32:0]        angle;
        logic [16:0]        hue_raw;
        hsi_out_t           res;
    } hsi_pipe_t;

    // Arithmetic right shift that rounds toward zero.
    function automatic logic signed [43:0] shift_tz(input logic signed [43:0] v, input int k);
        logic signed [43:0] mag;
        mag = v[43] ? -v : v;
        mag = mag >>> k;
        return v[43] ? -mag : mag;
    endfunction

    // Datapath of pipeline stage k, working on the register contents of stage k-1.
    function automatic hsi_pipe_t stage_fn(input logic [4:0] k, input hsi_pipe_t d);
        hsi_pipe_t q;
        logic [7:0] mn;
        logic signed [10:0] xs;
        logic signed [8:0] ys;
        logic [9:0] ax_mag;
        logic [7:0] ay_mag;
        logic [9:0] dif;
        logic [38:0] iprod;
        logic [18:0] irem;
        logic [10:0] iq;
        logic [20:0] dsh;
        int b;
        int it;
        logic signed [43:0] dx;
        logic signed [43:0] dy;
        logic signed [33:0] zc;
        logic [48:0] hprod;
        logic [9:0] sat;
        q = d;
        if (k == 5'd0) begin
            mn = d.red;
            if (d.green < mn) mn = d.green;
            if (d.blue < mn) mn = d.blue;
            q.sum = 10'(d.red) + 10'(d.green) + 10'(d.blue);
            xs = 11'(signed'({3'b0, d.red}) * 2) - signed'({3'b0, d.green})
                 - signed'({3'b0, d.blue});
            ys = signed'({1'b0, d.green}) - signed'({1'b0, d.blue});
            q.x_neg = xs[10];
            q.y_neg = ys[8];
            ax_mag = 10'(xs[10] ? -xs : xs);
            ay_mag = 8'(ys[8] ? -ys : ys);
            q.cx = signed'({4'b0, ax_mag, 30'b0});
            q.cy = signed'({5'b0, 39'(ay_mag) * 39'(SQRT3_Q30)});
            q.cz = '0;
            dif = q.sum - 10'(11'(mn) * 11'd3);
            q.sat_rem = 21'(dif) * 21'd2000 + 21'(q.sum);
            q.sat_den = {q.sum, 1'b0};
            q.sat_q = '0;
            q.int_n = 19'(q.sum) * 19'd400 + 19'd153;
        end else begin
            if (k == 5'd1) begin
                iprod = 39'(d.int_n) * 39'(INT_RECIP);
                q.int_q = iprod[38:28];
            end
            if (k == 5'd2) begin
                irem = d.int_n - 19'(d.int_q) * 19'(INT_DIV);
                iq = d.int_q;
                if (irem >= 19'(INT_DIV)) iq = iq + 11'd1;
                if (iq > MILLI_MAX) iq = MILLI_MAX;
                q.int_q = iq;
            end
            // one quotient bit per stage, most significant first
            if (k <= 5'(DIV_BITS)) begin
                b = DIV_BITS - int'(k);
                dsh = 21'(d.sat_den) << b;
                if (d.sat_rem >= dsh) begin
                    q.sat_rem = d.sat_rem - dsh;
                    q.sat_q = d.sat_q | (10'd1 << b);
                end
            end
            // two vectoring iterations per stage
            if (k <= 5'(CORDIC_STEPS / 2)) begin
                for (int j = 0; j < 2; j++) begin
                    it = 2 * (int'(k) - 1) + j;
                    dx = shift_tz(q.cy, it);
                    dy = shift_tz(q.cx, it);
                    if (!q.cy[43]) begin
                        q.cx = q.cx + dx;
                        q.cy = q.cy - dy;
                        q.cz = q.cz + signed'({2'b0, ATAN_TURNS[it]});
                    end else begin
                        q.cx = q.cx - dx;
                        q.cy = q.cy + dy;
                        q.cz = q.cz - signed'({2'b0, ATAN_TURNS[it]});
                    end
                end
            end
            if (k == 5'(CORDIC_STEPS / 2 + 1)) begin
                zc = d.cz;
                if (zc[33]) zc = '0;
                if (zc > signed'({1'b0, QUARTER_TURN})) zc = signed'({1'b0, QUARTER_TURN});
                if (!d.x_neg && !d.y_neg) q.angle = zc[32:0];
                else if (d.x_neg && !d.y_neg) q.angle = HALF_TURN - zc[32:0];
                else if (d.x_neg) q.angle = HALF_TURN + zc[32:0];
                else q.angle = FULL_TURN - zc[32:0];
            end
            if (k == 5'(CORDIC_STEPS / 2 + 2)) begin
                hprod = 49'(d.angle) * 49'(HUE_SCALE) + 49'(HALF_TURN);
                q.hue_raw = hprod[48:32];
            end
            if (k == 5'(NUM_STAGES - 1)) begin
                sat = d.sat_q;
                if (sat > MILLI_MAX[9:0]) sat = MILLI_MAX[9:0];
                if (d.sum == '0) sat = '0;
                q.res.saturation_milli = sat;
                q.res.intensity_milli = d.int_q[9:0];
                if (sat == '0 || d.hue_raw >= 17'(HUE_SCALE)) q.res.hue_centideg = '0;
                else q.res.hue_centideg = d.hue_raw[15:0];
            end
        end
        return q;
    endfunction

endpackage
`default_nettype wire

@@ rtl/hsi_pipe_ctrl.sv @@
// Valid tracking and per-stage load enables for the HSI pipeline, with bubble collapse.
`default_nettype none
module hsi_pipe_ctrl
    import hsi_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [NUM_STAGES-1:0]      stage_en
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    // a stage may load when it is empty or its item moves on
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = valid_reg;
        if (stage_en[0]) valid_next[0] = s_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

endmodule
`default_nettype wire

@@ rtl/rgb_to_hsi_converter.sv @@
// Top level: streaming RGB to HSI pixel converter.
// Input channel s_valid/s_ready/s_data carries one RGB pixel, 8 bits per channel, per item.
// Output channel m_valid/m_ready/m_data carries hue in hundredths of a degree,
// saturation and intensity in thousandths, one result item per pixel, in order.
// The datapath is a 16-stage pipeline: setup, twelve stages of two CORDIC
// vectoring iterations each (the saturation divider retires one quotient bit
// per stage alongside), quadrant fold, hue scaling multiply and final clamp.
// Each accepted pixel is registered in every stage in turn, setup first;
// throughput is one pixel per clock while m_ready stays high.
// When the receiver stalls, full stages hold; empty stages keep filling, so
// s_ready drops only once every stage holds an item.
// Reset (aresetn low, synchronous) empties the pipeline; no data is lost
// other than items in flight at that time.
`default_nettype none
module rgb_to_hsi_converter
    import hsi_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire hsi_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output hsi_out_t      m_data
);

    logic [NUM_STAGES-1:0] stage_en;
    hsi_pipe_t stage_reg [NUM_STAGES];
    hsi_pipe_t stage_next [NUM_STAGES];
    hsi_pipe_t seed;

    hsi_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stage_en (stage_en)
    );

    always_comb begin
        seed = '0;
        seed.red = s_data.red;
        seed.green = s_data.green;
        seed.blue = s_data.blue;
    end

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign stage_next[g] = stage_fn(5'(g), seed);
        end else begin : g_rest
            assign stage_next[g] = stage_fn(5'(g), stage_reg[g-1]);
        end

        always_ff @(posedge aclk) begin
            if (stage_en[g]) begin
                stage_reg[g] <= stage_next[g];
            end
        end
    end

    assign m_data = stage_reg[NUM_STAGES-1].res;

endmodule
`default_nettype wire

@@ tb/tb_rgb_to_hsi_converter.sv @@
// Testbench for the RGB to HSI converter: random and corner pixels against a fixed-point predictor.
`timescale 1ns / 1ps
module tb_rgb_to_hsi_converter
    import hsi_pkg::*;
();

    localparam int PIPE_LATENCY = 16;
    localparam longint CYCLE_LIMIT = 400000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    hsi_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    hsi_out_t m_data;

    hsi_in_t  pixel_queue[$];
    hsi_out_t hsi_expected[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_sender;
    bit       in_accepted = 1'b0;
    int       mismatches = 0;
    int       pixels_sent = 0;
    int       results_seen = 0;
    longint   cycle_count = 0;

    rgb_to_hsi_converter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic longint trunc_shift(longint v, int k);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = mag >> k;
        return (v < 0) ? -mag : mag;
    endfunction

    // Fixed-point HSI of one pixel: CORDIC angle of (2R-G-B, sqrt3*(G-B)).
    function automatic hsi_out_t pixel_to_hsi(hsi_in_t px);
        longint r, g, b, sum, mn, inten, sat, hue, xs, ys;
        longint x, y, z, dx, dy, angle;
        hsi_out_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        sum = r + g + b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        inten = (sum * 400 + 153) / 306;
        if (inten > 1000) inten = 1000;
        sat = 0;
        hue = 0;
        if (sum != 0) begin
            sat = (2000 * (sum - 3 * mn) + sum) / (2 * sum);
            if (sat > 1000) sat = 1000;
        end
        if (sat != 0) begin
            xs = 2 * r - g - b;
            ys = g - b;
            x = ((xs < 0) ? -xs : xs) << 30;
            y = ((ys < 0) ? -ys : ys) * longint'(SQRT3_Q30);
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = trunc_shift(y, i);
                dy = trunc_shift(x, i);
                if (y >= 0) begin
                    x += dx;
                    y -= dy;
                    z += longint'(ATAN_TURNS[i]);
                end else begin
                    x -= dx;
                    y += dy;
                    z -= longint'(ATAN_TURNS[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > longint'(QUARTER_TURN)) z = longint'(QUARTER_TURN);
            if (xs >= 0 && ys >= 0) angle = z;
            else if (xs < 0 && ys >= 0) angle = longint'(HALF_TURN) - z;
            else if (xs < 0) angle = longint'(HALF_TURN) + z;
            else angle = longint'(FULL_TURN) - z;
            hue = (angle * 36000 + longint'(HALF_TURN)) >>> 32;
            if (hue >= 36000) hue = 0;
        end
        res.hue_centideg = 16'(hue);
        res.saturation_milli = 10'(sat);
        res.intensity_milli = 10'(inten);
        return res;
    endfunction

    function automatic hsi_in_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        hsi_in_t px;
        px.red = r;
        px.green = g;
        px.blue = b;
        return px;
    endfunction

    function automatic hsi_in_t random_pixel();
        hsi_in_t px;
        case ($urandom_range(0, 5))
            0: begin
                // gray-ish: channels close together
                px.red = 8'($urandom_range(0, 255));
                px.green = 8'(int'(px.red) + $urandom_range(0, 2));
                px.blue = 8'(int'(px.red) + $urandom_range(0, 2));
            end
            1: px = make_pixel($urandom_range(0, 255) & 8'hf0 ? 8'hff : 8'h00,
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)));
            default: px = hsi_in_t'($urandom);
        endcase
        return px;
    endfunction

    // Driver: present the next pending item once the current one was taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else if (!s_valid || in_accepted) begin
            if (pixel_queue.size() > 0 && !hold_sender
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                s_data <= pixel_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Record the expectation at acceptance, check each result in order.
    always @(posedge aclk) begin
        cycle_count++;
        in_accepted = aresetn && s_valid && s_ready;
        if (in_accepted) begin
            hsi_expected.push_back(pixel_to_hsi(s_data));
            pixels_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (hsi_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                mismatches++;
            end else begin
                hsi_out_t want;
                want = hsi_expected.pop_front();
                if (want.hue_centideg !== m_data.hue_centideg
                        || want.saturation_milli !== m_data.saturation_milli
                        || want.intensity_milli !== m_data.intensity_milli) begin
                    $display("%0t: mismatch expected h=%0d s=%0d i=%0d actual h=%0d s=%0d i=%0d",
                             $time, want.hue_centideg, want.saturation_milli,
                             want.intensity_milli, m_data.hue_centideg,
                             m_data.saturation_milli, m_data.intensity_milli);
                    mismatches++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic drain_pipeline();
        while (pixel_queue.size() > 0 || s_valid) @(posedge aclk);
        while (hsi_expected.size() > 0) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        hold_sender = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 46;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // corners: black, white, primaries, secondaries, near-gray, hue wrap
        pixel_queue.push_back(make_pixel(8'd0, 8'd0, 8'd0));
        pixel_queue.push_back(make_pixel(8'd255, 8'd255, 8'd255));
        pixel_queue.push_back(make_pixel(8'd255, 8'd0, 8'd0));
        pixel_queue.push_back(make_pixel(8'd0, 8'd255, 8'd0));
        pixel_queue.push_back(make_pixel(8'd0, 8'd0, 8'd255));
        pixel_queue.push_back(make_pixel(8'd255, 8'd255, 8'd0));
        pixel_queue.push_back(make_pixel(8'd0, 8'd255, 8'd255));
        pixel_queue.push_back(make_pixel(8'd255, 8'd0, 8'd255));
        pixel_queue.push_back(make_pixel(8'd1, 8'd0, 8'd0));
        pixel_queue.push_back(make_pixel(8'd0, 8'd0, 8'd1));
        pixel_queue.push_back(make_pixel(8'd255, 8'd254, 8'd255));
        pixel_queue.push_back(make_pixel(8'd200, 8'd200, 8'd201));
        pixel_queue.push_back(make_pixel(8'd255, 8'd0, 8'd1));
        pixel_queue.push_back(make_pixel(8'd255, 8'd1, 8'd0));
        pixel_queue.push_back(make_pixel(8'd128, 8'd127, 8'd128));
        pixel_queue.push_back(make_pixel(8'd170, 8'd85, 8'd0));
        pixel_queue.push_back(make_pixel(8'd0, 8'd128, 8'd64));
        pixel_queue.push_back(make_pixel(8'h55, 8'hAA, 8'h55));
        pixel_queue.push_back(make_pixel(8'hAA, 8'h55, 8'hAA));
        for (int i = 0; i < 300; i++) pixel_queue.push_back(random_pixel());

        // hold off midway until every expected result is in, then resume
        repeat (200) @(posedge aclk);
        hold_sender = 1'b1;
        while (s_valid || hsi_expected.size() > 0) @(posedge aclk);
        hold_sender = 1'b0;
        drain_pipeline();

        // swap idling between sender and receiver
        send_idle_pct = 46;
        recv_idle_pct = 20;
        for (int i = 0; i < 320; i++) pixel_queue.push_back(random_pixel());
        drain_pipeline();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 310; i++) pixel_queue.push_back(random_pixel());
        drain_pipeline();
        repeat (PIPE_LATENCY + 4) @(posedge aclk);

        $display("Sent %0d pixels, checked %0d results under three stall patterns.",
                 pixels_sent, results_seen);
        if (mismatches == 0 && hsi_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ rgb_to_hsi_converter.f @@
rtl/hsi_pkg.sv
rtl/hsi_pipe_ctrl.sv
rtl/rgb_to_hsi_converter.sv
tb/tb_rgb_to_hsi_converter.sv
